/* rtl/sfrd_pkg.sv */
package sfrd_pkg;

   localparam int FRAME_LEN   = 16;
   localparam int PAT_WIDTH   = 15;
   localparam int CNT_WIDTH   = 11;
   localparam int POS_WIDTH   = $clog2(FRAME_LEN);
   localparam int HOLD_MIN    = 10;
   localparam int HOLD_MAX    = 2000;

   typedef enum logic [1:0] {
      OP_FIRE    = 2'd0,
      OP_RELEASE = 2'd1,
      OP_TICK    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_SHIFT = 1'b1
   } state_type;

   // one bit pair held by a chain cell
   typedef struct packed {
      logic right;
      logic left;
   } pair_type;

   typedef struct packed {
      logic load;
      logic shift;
   } chain_ctrl_type;

   // clamp a hold time to HOLD_MIN..HOLD_MAX
   function automatic logic [CNT_WIDTH-1:0] clamp_hold(input logic [15:0] h);
      logic [CNT_WIDTH-1:0] r;
      if (h < 16'(HOLD_MIN)) begin
         r = CNT_WIDTH'(HOLD_MIN);
      end else if (h > 16'(HOLD_MAX)) begin
         r = CNT_WIDTH'(HOLD_MAX);
      end else begin
         r = h[CNT_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/sfrd_if.sv */
interface sfrd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic        board;
   logic [15:0] mask;
   logic [15:0] hold_ms;

   modport source (output valid, op, board, mask, hold_ms, input ready);
   modport sink   (input valid, op, board, mask, hold_ms, output ready);
endinterface

interface sfrd_rsp_if;
   logic        valid;
   logic        ready;
   logic        bit_right;
   logic        bit_left;
   logic        last;
   logic [14:0] right_mask;
   logic [14:0] left_mask;

   modport source (output valid, bit_right, bit_left, last, right_mask, left_mask,
                   input ready);
   modport sink   (input valid, bit_right, bit_left, last, right_mask, left_mask,
                   output ready);
endinterface

/* rtl/sfrd_cell.sv */
module sfrd_cell (
   input  logic                    clock,
   input  sfrd_pkg::chain_ctrl_type ctrl,
   input  sfrd_pkg::pair_type      load_pair,
   input  sfrd_pkg::pair_type      prev_pair,
   output sfrd_pkg::pair_type      pair
);
   import sfrd_pkg::*;

   pair_type pair_ff;
   pair_type pair_in;

   always_comb begin
      pair_in = pair_ff;
      if (ctrl.load) begin
         pair_in = load_pair;
      end else if (ctrl.shift) begin
         pair_in = prev_pair;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair = pair_ff;

endmodule

/* rtl/sfrd_chain.sv */
module sfrd_chain (
   input  logic                                clock,
   input  sfrd_pkg::chain_ctrl_type            ctrl,
   input  logic [sfrd_pkg::FRAME_LEN-1:0]      load_right,
   input  logic [sfrd_pkg::FRAME_LEN-1:0]      load_left,
   output sfrd_pkg::pair_type                  head
);
   import sfrd_pkg::*;

   pair_type cell_out [FRAME_LEN];

   // cell 0 takes zeros in, the top cell presents the msb first
   for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
      pair_type prev_p;
      pair_type load_p;
      if (i == 0) begin : g_first
         assign prev_p = '0;
      end else begin : g_next
         assign prev_p = cell_out[i-1];
      end
      assign load_p.right = load_right[i];
      assign load_p.left  = load_left[i];
      sfrd_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .load_pair (load_p),
         .prev_pair (prev_p),
         .pair      (cell_out[i])
      );
   end

   assign head = cell_out[FRAME_LEN-1];

endmodule

/* rtl/solenoid_fire_release_driver.sv */
// channel | dir | fields                                         | handshake
// req     | in  | op, board, mask, hold_ms                       | valid/ready
// rsp     | out | bit_right, bit_left, last, right_mask, left_mask| valid/ready
//
// each frame is 16 bit pairs, one response per cycle while rsp.ready is high,
// shifted out of a 16-cell chain; a request launches no frame, one frame or two frames
// a request is taken only when no frame is in flight (req.ready high in idle)
// a stalled response simply holds the chain; nothing is lost or repeated
// reset (synchronous, active high) clears patterns, countdowns and control state
module solenoid_fire_release_driver (
   input logic       clock,
   input logic       reset,
   sfrd_req_if.sink  req,
   sfrd_rsp_if.source rsp
);
   import sfrd_pkg::*;

   // latched board patterns and hold countdowns (0 = inactive)
   logic [PAT_WIDTH-1:0] right_pat_ff, right_pat_in;
   logic [PAT_WIDTH-1:0] left_pat_ff,  left_pat_in;
   logic [CNT_WIDTH-1:0] right_rem_ff, right_rem_in;
   logic [CNT_WIDTH-1:0] left_rem_ff,  left_rem_in;

   // second frame owed after both boards expire on one tick
   logic pending_ff, pending_in;

   // position in the frame being shifted
   logic [POS_WIDTH-1:0] pos_ff, pos_in;

   // mask snapshot shown with every pair of a frame
   logic [PAT_WIDTH-1:0] rmask_ff, rmask_in;
   logic [PAT_WIDTH-1:0] lmask_ff, lmask_in;

   state_type state_ff, state_in;

   logic           req_take;
   logic           rsp_take;
   logic           frame_end;
   logic           frame_start;
   logic           right_exp;
   logic           left_exp;
   chain_ctrl_type chain_ctrl;
   pair_type       head;

   assign req_take  = req.valid & req.ready;
   assign rsp_take  = rsp.valid & rsp.ready;
   assign frame_end = rsp_take & (pos_ff == POS_WIDTH'(FRAME_LEN - 1));

   // countdowns expire when an active count steps from one to zero
   assign right_exp = (right_rem_ff == CNT_WIDTH'(1));
   assign left_exp  = (left_rem_ff  == CNT_WIDTH'(1));

   // board state update and frame launch
   always_comb begin
      right_pat_in = right_pat_ff;
      left_pat_in  = left_pat_ff;
      right_rem_in = right_rem_ff;
      left_rem_in  = left_rem_ff;
      pending_in   = pending_ff;
      frame_start  = 1'b0;

      if (req_take) begin
         case (op_type'(req.op))
            OP_FIRE: begin
               if (req.board) begin
                  left_pat_in = req.mask[PAT_WIDTH-1:0];
                  left_rem_in = clamp_hold(req.hold_ms);
               end else begin
                  right_pat_in = req.mask[PAT_WIDTH-1:0];
                  right_rem_in = clamp_hold(req.hold_ms);
               end
               frame_start = 1'b1;
            end
            OP_RELEASE: begin
               if (req.board) begin
                  left_pat_in = '0;
                  left_rem_in = '0;
               end else begin
                  right_pat_in = '0;
                  right_rem_in = '0;
               end
               frame_start = 1'b1;
            end
            OP_TICK: begin
               if (right_rem_ff != '0) begin
                  right_rem_in = right_rem_ff - CNT_WIDTH'(1);
               end
               if (left_rem_ff != '0) begin
                  left_rem_in = left_rem_ff - CNT_WIDTH'(1);
               end
               if (right_exp) begin
                  right_pat_in = '0;
               end
               // with both expiring, the first frame still shows the old left pattern
               if (left_exp) begin
                  if (right_exp) begin
                     pending_in = 1'b1;
                  end else begin
                     left_pat_in = '0;
                  end
               end
               frame_start = right_exp | left_exp;
            end
            default: begin
            end
         endcase
      end else if (frame_end && pending_ff) begin
         // second frame of a double expiry: left board now cleared
         left_pat_in = '0;
         pending_in  = 1'b0;
         frame_start = 1'b1;
      end
   end

   // frame position and mask snapshot
   always_comb begin
      pos_in   = pos_ff;
      rmask_in = rmask_ff;
      lmask_in = lmask_ff;
      if (frame_start) begin
         pos_in   = '0;
         rmask_in = right_pat_in;
         lmask_in = left_pat_in;
      end else if (rsp_take) begin
         pos_in = pos_ff + POS_WIDTH'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (frame_start) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (frame_end && !pending_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req.ready = 1'b1;
         ST_SHIFT: rsp.valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         right_pat_ff <= '0;
         left_pat_ff  <= '0;
         right_rem_ff <= '0;
         left_rem_ff  <= '0;
         pending_ff   <= 1'b0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         right_pat_ff <= right_pat_in;
         left_pat_ff  <= left_pat_in;
         right_rem_ff <= right_rem_in;
         left_rem_ff  <= left_rem_in;
         pending_ff   <= pending_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rmask_ff <= rmask_in;
      lmask_ff <= lmask_in;
   end

   // load has priority; otherwise each taken response moves the chain one cell
   assign chain_ctrl.load  = frame_start;
   assign chain_ctrl.shift = rsp_take;

   // bit 15 of every frame is a zero pad
   sfrd_chain u_chain (
      .clock      (clock),
      .ctrl       (chain_ctrl),
      .load_right ({1'b0, right_pat_in}),
      .load_left  ({1'b0, left_pat_in}),
      .head       (head)
   );

   assign rsp.bit_right  = head.right;
   assign rsp.bit_left   = head.left;
   assign rsp.last       = (pos_ff == POS_WIDTH'(FRAME_LEN - 1));
   assign rsp.right_mask = rmask_ff;
   assign rsp.left_mask  = lmask_ff;

endmodule
